>>> rtl/core/ctc_gd_pkg.sv
// ----------------------------------------------------------------------------
// ctc_gd_pkg
// Shared types and constants of the greedy CTC decoder: request payloads,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package ctc_gd_pkg;

  // field widths
  localparam int unsigned ScoreW = 16;
  localparam int unsigned IdxW   = 13;
  localparam int unsigned SumW   = 24;
  localparam int unsigned CntW   = 9;

  // number of class slots seen by the decoder
  localparam int unsigned MaxClasses = 8192;
  localparam int unsigned IdxHwLimit = (1 << IdxW) - 1;
  localparam int unsigned IdxLastInt = (MaxClasses - 1 < IdxHwLimit) ?
                                       (MaxClasses - 1) : IdxHwLimit;
  localparam logic [IdxW-1:0] IdxLast = IdxLastInt[IdxW-1:0];

  // accumulator limits
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [SumW:0]   SumMax = {1'b0, {SumW{1'b1}}};

  // blank class
  localparam logic [IdxW-1:0] BlankIdx = '0;

  // result kinds
  localparam logic KindLabel = 1'b0;
  localparam logic KindAvg   = 1'b1;

  // serial divider: one quotient bit per cycle
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DivSteps - 1);

  typedef struct packed {
    logic [ScoreW-1:0] class_score;
    logic              end_of_frame;
    logic              end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [IdxW-1:0]   label_index;
    logic [ScoreW-1:0] average_score;
    logic              no_labels;
    logic              last_result;
  } out_item_t;

  typedef enum logic [1:0] {
    StRun,
    StDiv,
    StAvg
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic load_avg;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
    logic div_last;
  } stat_t;

endpackage

>>> rtl/core/ctc_gd_ctrl.sv
// ----------------------------------------------------------------------------
// ctc_gd_ctrl
// Sequencer of the decoder: streams scores, runs the serial divider at
// sequence end and hands the average to the output register.
// ----------------------------------------------------------------------------
module ctc_gd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_eos_i,
  input  logic              out_ready_i,
  input  ctc_gd_pkg::stat_t stat_i,
  output logic              in_ready_o,
  output ctc_gd_pkg::cmd_t  cmd_o
);

  ctc_gd_pkg::state_e state_q, state_d;
  logic               slot_free;

  // output slot is free or drains this cycle
  assign slot_free = !stat_i.out_valid || out_ready_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctc_gd_pkg::StRun;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ctc_gd_pkg::StRun: begin
        in_ready_o   = slot_free;
        cmd_o.accept = in_valid_i && slot_free;
        if (in_valid_i && slot_free && in_eos_i) begin
          cmd_o.div_start = 1'b1;
          state_d         = ctc_gd_pkg::StDiv;
        end
      end
      ctc_gd_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ctc_gd_pkg::StAvg;
        end
      end
      ctc_gd_pkg::StAvg: begin
        if (slot_free) begin
          cmd_o.load_avg = 1'b1;
          state_d        = ctc_gd_pkg::StRun;
        end
      end
      default: begin
        state_d = ctc_gd_pkg::StRun;
      end
    endcase
  end

endmodule

>>> rtl/core/ctc_gd_dp.sv
// ----------------------------------------------------------------------------
// ctc_gd_dp
// Datapath of the decoder: frame maximum tracking, label emission, score
// accumulation, restoring serial divider and the output register.
// ----------------------------------------------------------------------------
module ctc_gd_dp #(
  parameter int unsigned MaxClasses = ctc_gd_pkg::MaxClasses
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctc_gd_pkg::in_item_t  in_data_i,
  input  logic                  out_ready_i,
  input  ctc_gd_pkg::cmd_t      cmd_i,
  output ctc_gd_pkg::stat_t     stat_o,
  output logic                  out_valid_o,
  output ctc_gd_pkg::out_item_t out_data_o
);

  localparam int unsigned ScoreW = ctc_gd_pkg::ScoreW;
  localparam int unsigned IdxW   = ctc_gd_pkg::IdxW;
  localparam int unsigned SumW   = ctc_gd_pkg::SumW;
  localparam int unsigned CntW   = ctc_gd_pkg::CntW;
  localparam int unsigned DivCntW = ctc_gd_pkg::DivCntW;

  // last class index the counter reaches
  localparam int unsigned IdxLastInt = (MaxClasses - 1 < ctc_gd_pkg::IdxHwLimit) ?
                                       (MaxClasses - 1) : ctc_gd_pkg::IdxHwLimit;
  localparam logic [IdxW-1:0] IdxLast = IdxLastInt[IdxW-1:0];

  logic [IdxW-1:0]    cls_cnt_q, cls_cnt_d;
  logic [ScoreW-1:0]  best_score_q, best_score_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [IdxW-1:0]    prev_win_q, prev_win_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    den_q, den_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               none_q, none_d;

  logic                  out_valid_q, out_valid_d;
  ctc_gd_pkg::out_item_t out_q, out_d;

  logic              eof;
  logic              upd;
  logic [ScoreW-1:0] win_score;
  logic [IdxW-1:0]   win_idx;
  logic              emit;
  logic [SumW:0]     sum_ext;
  logic              acc;
  logic [SumW-1:0]   sum_nxt;
  logic [CntW-1:0]   cnt_nxt;
  logic [CntW:0]     trial;
  logic              q_bit;
  logic [ScoreW-1:0] avg;

  // frame winner including the current score
  always_comb begin
    eof       = in_data_i.end_of_frame || in_data_i.end_of_sequence;
    upd       = (cls_cnt_q == '0) || (in_data_i.class_score > best_score_q);
    win_score = upd ? in_data_i.class_score : best_score_q;
    win_idx   = upd ? cls_cnt_q : best_idx_q;
    emit      = eof && (win_idx != ctc_gd_pkg::BlankIdx) && (win_idx != prev_win_q);
    sum_ext   = {1'b0, sum_q} + {{(SumW + 1 - ScoreW){1'b0}}, win_score};
    acc       = emit && (cnt_q < ctc_gd_pkg::CntMax) && (sum_ext <= ctc_gd_pkg::SumMax);
    sum_nxt   = acc ? sum_ext[SumW-1:0] : sum_q;
    cnt_nxt   = acc ? cnt_q + CntW'(1) : cnt_q;
  end

  // divider step and clamped average
  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    q_bit = (trial >= {1'b0, den_q});
    if (none_q) begin
      avg = '0;
    end else if (quo_q[SumW-1:ScoreW] != '0) begin
      avg = {ScoreW{1'b1}};
    end else begin
      avg = quo_q[ScoreW-1:0];
    end
  end

  // decoder state update
  always_comb begin
    cls_cnt_d    = cls_cnt_q;
    best_score_d = best_score_q;
    best_idx_d   = best_idx_q;
    prev_win_d   = prev_win_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    if (cmd_i.accept) begin
      if (eof) begin
        cls_cnt_d    = '0;
        best_score_d = '0;
        best_idx_d   = '0;
        prev_win_d   = in_data_i.end_of_sequence ? ctc_gd_pkg::BlankIdx : win_idx;
      end else begin
        cls_cnt_d    = (cls_cnt_q < IdxLast) ? cls_cnt_q + IdxW'(1) : cls_cnt_q;
        best_score_d = win_score;
        best_idx_d   = win_idx;
      end
      if (in_data_i.end_of_sequence) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_nxt;
        cnt_d = cnt_nxt;
      end
    end
  end

  // serial divider
  always_comb begin
    quo_d     = quo_q;
    rem_d     = rem_q;
    den_d     = den_q;
    div_cnt_d = div_cnt_q;
    none_d    = none_q;
    if (cmd_i.div_start) begin
      quo_d     = sum_nxt;
      rem_d     = '0;
      den_d     = cnt_nxt;
      div_cnt_d = '0;
      none_d    = (cnt_nxt == '0);
    end else if (cmd_i.div_step) begin
      quo_d     = {quo_q[SumW-2:0], q_bit};
      rem_d     = q_bit ? CntW'(trial - {1'b0, den_q}) : trial[CntW-1:0];
      div_cnt_d = div_cnt_q + DivCntW'(1);
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cmd_i.accept && emit) begin
      out_valid_d         = 1'b1;
      out_d.result_kind   = ctc_gd_pkg::KindLabel;
      out_d.label_index   = win_idx;
      out_d.average_score = '0;
      out_d.no_labels     = 1'b0;
      out_d.last_result   = 1'b0;
    end else if (cmd_i.load_avg) begin
      out_valid_d         = 1'b1;
      out_d.result_kind   = ctc_gd_pkg::KindAvg;
      out_d.label_index   = '0;
      out_d.average_score = avg;
      out_d.no_labels     = none_q;
      out_d.last_result   = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_cnt_q    <= '0;
      best_score_q <= '0;
      best_idx_q   <= '0;
      prev_win_q   <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cls_cnt_q    <= cls_cnt_d;
      best_score_q <= best_score_d;
      best_idx_q   <= best_idx_d;
      prev_win_q   <= prev_win_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      div_cnt_q    <= div_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    none_q <= none_d;
    out_q  <= out_d;
  end

  assign stat_o.out_valid = out_valid_q;
  assign stat_o.div_last  = (div_cnt_q == ctc_gd_pkg::DivLastStep);
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule

>>> rtl/core/ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// ctc_greedy_decoder
// Greedy best-path CTC decoder over a stream of class scores.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   ctc_gd_pkg::in_item_t
//   out      output     out_valid_o/out_ready_i ctc_gd_pkg::out_item_t
//
// One score request is taken per cycle while the output register is free or
// being drained; a label result appears the cycle after its frame ends.
// At sequence end the input stalls while the bit-serial divider runs and
// until the average is loaded into the output register. Reset clears the
// control state only; the output register holds one result.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder #(
  parameter int unsigned MaxClasses = ctc_gd_pkg::MaxClasses
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ctc_gd_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctc_gd_pkg::out_item_t out_data_o
);

  ctc_gd_pkg::cmd_t  cmd;
  ctc_gd_pkg::stat_t stat;

  // sequencer
  ctc_gd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eos_i    (in_data_i.end_of_sequence),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // datapath
  ctc_gd_dp #(
    .MaxClasses (MaxClasses)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb_ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// tb_ctc_greedy_decoder
// Self-checking bench for the greedy CTC decoder. A queue of score requests
// feeds a clocked driver; a clocked monitor compares every result with the
// label/average stream predicted from the accepted requests. Phases vary the
// idle rates on both channels, and one long output stall fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ctc_greedy_decoder;

  localparam int unsigned ScoreW = ctc_gd_pkg::ScoreW;
  localparam int unsigned IdxW   = ctc_gd_pkg::IdxW;
  localparam int unsigned SumW   = ctc_gd_pkg::SumW;
  localparam int unsigned CntW   = ctc_gd_pkg::CntW;

  localparam int unsigned PhaseItems    = 120;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned WatchdogLimit = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  ctc_gd_pkg::in_item_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ctc_gd_pkg::out_item_t out_data;

  ctc_greedy_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // score requests waiting to be sent, decoder results waiting to arrive
  ctc_gd_pkg::in_item_t  pending_scores[$];
  ctc_gd_pkg::out_item_t expected_decodes[$];

  int unsigned error_count = 0;
  int unsigned phase_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  ctc_gd_pkg::out_item_t want;
  logic                  sender_busy;

  // predicted decoder state
  logic [IdxW-1:0]   cls_cnt = '0;
  logic [ScoreW-1:0] frame_best = '0;
  logic [IdxW-1:0]   frame_best_idx = '0;
  logic [IdxW-1:0]   prev_win = '0;
  logic [SumW-1:0]   label_sum = '0;
  logic [CntW-1:0]   label_cnt = '0;

  // predict the results caused by one accepted score request
  task automatic decode_score(input ctc_gd_pkg::in_item_t req);
    ctc_gd_pkg::out_item_t res;
    logic                  seq_end;
    logic                  frame_end;
    logic [IdxW-1:0]       win;
    logic [SumW:0]         sum_next;
    logic [SumW-1:0]       quot;
    seq_end   = req.end_of_sequence;
    frame_end = req.end_of_frame | seq_end;
    // running maximum, the first index wins a tie
    if (cls_cnt == '0 || req.class_score > frame_best) begin
      frame_best     = req.class_score;
      frame_best_idx = cls_cnt;
    end
    if (cls_cnt < ctc_gd_pkg::IdxLast) begin
      cls_cnt = cls_cnt + 1'b1;
    end
    // frame end: emit a new non-blank winner
    if (frame_end) begin
      win = frame_best_idx;
      if (win != ctc_gd_pkg::BlankIdx && win != prev_win) begin
        res             = '0;
        res.result_kind = ctc_gd_pkg::KindLabel;
        res.label_index = win;
        expected_decodes = {expected_decodes, res};
        sum_next = {1'b0, label_sum} + (SumW + 1)'(frame_best);
        if (label_cnt < ctc_gd_pkg::CntMax && sum_next <= ctc_gd_pkg::SumMax) begin
          label_sum = sum_next[SumW-1:0];
          label_cnt = label_cnt + 1'b1;
        end
      end
      prev_win       = win;
      cls_cnt        = '0;
      frame_best     = '0;
      frame_best_idx = '0;
    end
    // sequence end: mean of the accumulated label scores
    if (seq_end) begin
      res             = '0;
      res.result_kind = ctc_gd_pkg::KindAvg;
      res.last_result = 1'b1;
      if (label_cnt == '0) begin
        res.no_labels = 1'b1;
      end else begin
        quot = label_sum / SumW'(label_cnt);
        res.average_score = (quot > SumW'({ScoreW{1'b1}})) ? {ScoreW{1'b1}} :
                            quot[ScoreW-1:0];
      end
      expected_decodes = {expected_decodes, res};
      cls_cnt        = '0;
      frame_best     = '0;
      frame_best_idx = '0;
      prev_win       = ctc_gd_pkg::BlankIdx;
      label_sum      = '0;
      label_cnt      = '0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               exp_val, act_val);
      error_count++;
    end
  endtask

  // stimulus builders
  task automatic add_score(input int unsigned score, input bit eof, input bit eos);
    ctc_gd_pkg::in_item_t req;
    req.class_score     = score[ScoreW-1:0];
    req.end_of_frame    = eof;
    req.end_of_sequence = eos;
    pending_scores = {pending_scores, req};
    phase_items++;
  endtask

  function automatic int unsigned rand_score(input int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 0;
    if (pick == 1) return hi;
    return $urandom_range(hi, 0);
  endfunction

  // well-formed sequences with random content, some broken ones
  task automatic add_random_sequence();
    int unsigned n_frames;
    int unsigned n_cls;
    int unsigned hi;
    int unsigned pick;
    bit          noisy;
    bit          is_last;
    bit          seq_end;
    n_frames = $urandom_range(6, 1);
    noisy    = ($urandom_range(9) == 0);
    for (int unsigned f = 0; f < n_frames; f++) begin
      n_cls = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
      pick  = $urandom_range(2);
      hi    = (pick == 0) ? 3 : (pick == 1) ? 255 : 65535;
      for (int unsigned c = 0; c < n_cls; c++) begin
        is_last = (c == n_cls - 1);
        seq_end = is_last && (f == n_frames - 1);
        if (noisy) begin
          add_score($urandom_range(65535), $urandom_range(3) == 0,
                    seq_end || $urandom_range(15) == 0);
        end else begin
          // sequence end sometimes comes without its frame end flag
          add_score(rand_score(hi), is_last && !(seq_end && $urandom_range(7) == 0),
                    seq_end);
        end
      end
    end
  endtask

  task automatic add_directed();
    // empty sequence: the blank wins the only frame
    add_score(65535, 1'b1, 1'b1);
    // tie at the top, first index wins
    add_score(0, 1'b0, 1'b0);
    add_score(65535, 1'b0, 1'b0);
    add_score(65535, 1'b1, 1'b0);
    // same winner again, suppressed
    add_score(0, 1'b0, 1'b0);
    add_score(65535, 1'b1, 1'b0);
    // blank frame in between
    add_score(65535, 1'b0, 1'b0);
    add_score(0, 1'b1, 1'b0);
    // repeat after a blank is emitted again
    add_score(0, 1'b0, 1'b0);
    add_score(1, 1'b1, 1'b0);
    // all-zero frame
    add_score(0, 1'b0, 1'b0);
    add_score(0, 1'b0, 1'b0);
    add_score(0, 1'b1, 1'b0);
    // sequence end without frame end, label and average on one request
    add_score(0, 1'b0, 1'b0);
    add_score(5, 1'b0, 1'b0);
    add_score(7, 1'b0, 1'b1);
    // single-frame sequence with a label
    add_score(3, 1'b0, 1'b0);
    add_score(2, 1'b0, 1'b0);
    add_score(9, 1'b0, 1'b0);
    add_score(65535, 1'b1, 1'b1);
    // frame end flag set together with sequence end, no label
    add_score(12, 1'b0, 1'b0);
    add_score(12, 1'b1, 1'b1);
  endtask

  task automatic add_random_phase();
    phase_items = 0;
    while (phase_items < PhaseItems) begin
      add_random_sequence();
    end
  endtask

  task automatic wait_drained();
    while (pending_scores.size() != 0 || in_valid || expected_decodes.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      sender_busy = in_valid;
      if (in_valid && in_ready) begin
        decode_score(in_data);
        sender_busy = 1'b0;
      end
      if (!sender_busy) begin
        if (pending_scores.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_scores.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_decodes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = expected_decodes.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("label_index", want.label_index, out_data.label_index);
        check_field("average_score", want.average_score, out_data.average_score);
        check_field("no_labels", want.no_labels, out_data.no_labels);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // phases
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no idling: directed requests, then random ones under a long stall
    add_directed();
    wait_drained();
    add_random_phase();
    @(negedge clk_i);
    hold_token = hold_token + 1;
    wait_drained();

    // sender idle
    send_idle_pct = 55;
    recv_idle_pct = 0;
    add_random_phase();
    wait_drained();

    // receiver stalling
    send_idle_pct = 0;
    recv_idle_pct = 55;
    add_random_phase();
    wait_drained();

    // both
    send_idle_pct = 31;
    recv_idle_pct = 31;
    add_random_phase();
    wait_drained();

    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
